// ===== hdl/cdg_pkg.sv =====
// shared types and constants for the graphics command decoder
`timescale 1ns / 1ps
package cdg_pkg;
   localparam int FrameWidth  = 300;
   localparam int FrameHeight = 216;
   localparam int FrameDepth  = FrameWidth * FrameHeight;
   // each word holds one six-pixel tile row, tile columns are 6 wide
   localparam int ColWords    = (FrameWidth + 5) / 6;
   localparam int WordDepth   = ColWords * FrameHeight;
   localparam int WordAddrW   = $clog2(WordDepth);
   localparam int ColW        = $clog2(ColWords);

   localparam logic [5:0] InstrPreset     = 6'd1;
   localparam logic [5:0] InstrBorder     = 6'd2;
   localparam logic [5:0] InstrTile       = 6'd6;
   localparam logic [5:0] InstrScroll     = 6'd20;
   localparam logic [5:0] InstrScrollCopy = 6'd24;
   localparam logic [5:0] InstrTransp     = 6'd28;
   localparam logic [5:0] InstrPalLo      = 6'd30;
   localparam logic [5:0] InstrPalHi      = 6'd31;
   localparam logic [5:0] InstrTileXor    = 6'd38;

   localparam logic [1:0] StatusDone    = 2'd0;
   localparam logic [1:0] StatusUnimpl  = 2'd1;
   localparam logic [1:0] StatusUnknown = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request item
      logic rd;         // issue a memory read
      logic wr;         // write the word read back
      logic fill;       // write the preset word
      logic pal_wr;     // load the palette
      logic rsp_load;   // capture result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_read;
      logic is_tile;
      logic is_fill;
      logic is_pal;
      logic [1:0] status;
      logic last;       // current row or fill word is the last one
   } stat_type;

   function automatic logic [7:0] times15(input logic [3:0] v);
      return {v, 4'b0000} - {4'b0000, v};
   endfunction
endpackage

// ===== hdl/cdg_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module cdg_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== hdl/cdg_datapath.sv =====
// datapath: item registers, frame memory, palette and result register
`timescale 1ns / 1ps
module cdg_datapath import cdg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output stat_type     stat,
   input  logic         req_func,
   input  logic [5:0]   req_instruction,
   input  logic [47:0]  req_data_lo,
   input  logic [47:0]  req_data_hi,
   input  logic [8:0]   req_read_x,
   input  logic [7:0]   req_read_y,
   output logic [1:0]   rsp_status,
   output logic [3:0]   rsp_color_index,
   output logic [7:0]   rsp_red,
   output logic [7:0]   rsp_green,
   output logic [7:0]   rsp_blue
);
   logic         func_ff;
   logic [5:0]   instr_ff;
   logic [95:0]  data_ff;
   logic [2:0]   rsub_ff;     // pixel within word for a read
   logic         rin_ff;      // read is inside the frame
   logic [WordAddrW-1:0] addr_ff, addr_in;
   logic [3:0]   trow_ff, trow_in;
   logic [11:0]  pal_ff [16];
   logic [1:0]   status_ff;
   logic [3:0]   ci_ff;
   logic [7:0]   r_ff, g_ff, b_ff;

   logic [23:0]  rd_word, wr_word;
   logic [WordAddrW-1:0] mem_addr;
   logic         mem_wr;
   logic [1:0]   pkt_status;

   logic [5:0] sym [16];
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         sym[k] = data_ff[k*6 +: 6];
      end
   end

   logic [3:0]  c0, c1;
   logic [4:0]  ty;
   logic [5:0]  tx;
   logic [8:0]  py;
   logic [8:0]  px;
   logic [5:0]  bits;
   logic        row_ok;
   assign c0 = sym[0][3:0];
   assign c1 = sym[1][3:0];
   assign ty = sym[2][4:0];
   assign tx = sym[3];
   assign py = 9'(ty) * 9'd12 + 9'(trow_ff);
   assign px = 9'(tx) * 9'd6;
   assign row_ok = (py < 9'(FrameHeight)) && (tx < 6'(ColWords));

   always_comb begin
      bits = 6'd0;
      for (int r = 0; r < 12; r++) begin
         if (trow_ff == 4'(r)) bits = sym[4 + r];
      end
   end

   // new word: bit 5 is leftmost pixel, pixel p at [p*4 +: 4]
   always_comb begin
      for (int p = 0; p < 6; p++) begin
         logic [3:0] c;
         c = bits[5 - p] ? c1 : c0;
         if (px + 9'(p) >= 9'(FrameWidth)) begin
            wr_word[p*4 +: 4] = rd_word[p*4 +: 4];
         end else if (instr_ff == InstrTileXor) begin
            wr_word[p*4 +: 4] = rd_word[p*4 +: 4] ^ c;
         end else begin
            wr_word[p*4 +: 4] = c;
         end
      end
      if (cmd.fill) wr_word = {6{c0}};
   end

   logic [WordAddrW-1:0] tile_addr, read_addr;
   assign tile_addr = WordAddrW'(py) * WordAddrW'(ColWords) + WordAddrW'(tx);
   // column word by reciprocal multiply, exact over the frame width
   logic [18:0] rcol_prod;
   logic [ColW-1:0] rcol;
   assign rcol_prod = 19'(req_read_x) * 19'd683;
   assign rcol = rcol_prod[12 +: ColW];
   assign read_addr = WordAddrW'(req_read_y) * WordAddrW'(ColWords) + WordAddrW'(rcol);

   assign mem_wr = (cmd.wr && row_ok) || cmd.fill;
   assign mem_addr = addr_ff;

   cdg_ram #(.Width(24), .Depth(WordDepth)) u_frame (
      .clock   (clock),
      .wr_en   (mem_wr),
      .addr    (mem_addr),
      .wr_data (wr_word),
      .rd_data (rd_word)
   );

   always_comb begin
      addr_in = addr_ff;
      trow_in = trow_ff;
      if (cmd.load) begin
         addr_in = read_addr;
         trow_in = 4'd0;
      end else if (cmd.fill) begin
         addr_in = addr_ff + 1'b1;
      end else if (cmd.wr) begin
         trow_in = trow_ff + 1'b1;
      end else if (cmd.rd && !func_ff && instr_ff != InstrPreset) begin
         addr_in = tile_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         instr_ff <= req_instruction;
         data_ff  <= {req_data_hi, req_data_lo};
         rsub_ff  <= 3'(req_read_x - 9'(rcol) * 9'd6);
         rin_ff   <= (req_read_x < 9'(FrameWidth)) && (req_read_y < 8'(FrameHeight));
      end
      if (cmd.load && req_func == 1'b0 && req_instruction == InstrPreset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
      trow_ff <= trow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) pal_ff[i] <= 12'd0;
      end else if (cmd.pal_wr) begin
         for (int i = 0; i < 8; i++) begin
            pal_ff[{instr_ff[0], 3'(i)}] <= {sym[2*i][5:2],
                                           sym[2*i][1:0], sym[2*i+1][5:4],
                                           sym[2*i+1][3:0]};
         end
      end
   end

   logic [3:0]  ci;
   logic [11:0] ent;
   always_comb begin
      ci = 4'd0;
      for (int p = 0; p < 6; p++) begin
         if (rsub_ff == 3'(p)) ci = rd_word[p*4 +: 4];
      end
      if (!rin_ff) ci = 4'd0;
      ent = rin_ff ? pal_ff[ci] : 12'd0;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         status_ff <= func_ff ? StatusDone : stat.status;
         ci_ff     <= func_ff ? ci : 4'd0;
         r_ff      <= func_ff ? times15(ent[11:8]) : 8'd0;
         g_ff      <= func_ff ? times15(ent[7:4]) : 8'd0;
         b_ff      <= func_ff ? times15(ent[3:0]) : 8'd0;
      end
   end

   always_comb begin
      pkt_status = StatusDone;
      unique case (instr_ff) inside
         InstrPreset, InstrTile, InstrTileXor, InstrPalLo, InstrPalHi:
            pkt_status = StatusDone;
         InstrBorder, InstrScroll, InstrScrollCopy, InstrTransp:
            pkt_status = StatusUnimpl;
         default: pkt_status = StatusUnknown;
      endcase
   end
   assign stat.status  = pkt_status;
   assign stat.is_read = func_ff;
   assign stat.is_tile = !func_ff && (instr_ff == InstrTile || instr_ff == InstrTileXor);
   assign stat.is_fill = !func_ff && instr_ff == InstrPreset && sym[1][3:0] == 4'd0;
   assign stat.is_pal  = !func_ff && (instr_ff == InstrPalLo || instr_ff == InstrPalHi);
   assign stat.last    = cmd.fill ? (addr_ff == WordAddrW'(WordDepth - 1))
                                  : (trow_ff == 4'd11);

   assign rsp_status      = status_ff;
   assign rsp_color_index = ci_ff;
   assign rsp_red         = r_ff;
   assign rsp_green       = g_ff;
   assign rsp_blue        = b_ff;
endmodule

// ===== hdl/cdg_ctrl.sv =====
// controller state machine for the graphics command decoder
`timescale 1ns / 1ps
module cdg_ctrl import cdg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);
   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StDec   = 3'd1;
   localparam logic [2:0] StRead  = 3'd2;
   localparam logic [2:0] StWrite = 3'd3;
   localparam logic [2:0] StFill  = 3'd4;
   localparam logic [2:0] StRsp   = 3'd5;
   localparam logic [2:0] StWait  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       vld_ff, vld_in;

   assign req_ready = state_ff == StIdle;
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in = state_ff;
      vld_in   = vld_ff && !rsp_ready;
      cmd      = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StDec;
            end
         end
         StDec: begin
            if (stat.is_read) begin
               state_in = StWait;
            end else if (stat.is_tile) begin
               cmd.rd   = 1'b1;
               state_in = StRead;
            end else if (stat.is_fill) begin
               state_in = StFill;
            end else begin
               cmd.pal_wr = stat.is_pal;
               state_in   = StRsp;
            end
         end
         StRead: begin
            state_in = StWrite;
         end
         StWrite: begin
            cmd.wr = 1'b1;
            if (stat.last) state_in = StRsp;
            else begin
               state_in = StDec;
            end
         end
         StFill: begin
            cmd.fill = 1'b1;
            if (stat.last) state_in = StRsp;
         end
         StWait: begin
            state_in = StRsp;
         end
         StRsp: begin
            if (!vld_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               vld_in       = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.load, cmd.wr, cmd.fill, cmd.rsp_load}) <= 1)
      else $error("more than one command at once");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !rsp_ready |=> vld_ff)
      else $error("result dropped while stalled");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == StDec)
      else $error("item load did not start decode");
endmodule

// ===== hdl/cdg_graphics_command_decoder.sv =====
// top level of the graphics command decoder
`timescale 1ns / 1ps
// Takes one item at a time on the req_ channel (valid/ready) and gives one
// result item on the rsp_ channel (valid/ready) for each.
// A packet item (func 0) applies a subcode instruction; a read item (func 1)
// returns a pixel's palette index and its components times 15.
// The frame is held as words of six pixels, one tile row per word, in a
// single port memory; each tile row is read and then written back.
// A memory preset with repeat 0 writes one word a cycle over the whole frame.
// A new item is taken once the previous result is in the output register;
// it may still wait there for rsp_ready while the next item is worked on,
// and the next result waits until it is taken.
// Reset clears the palette to zero and empties the result register; the
// frame is undefined until written and needs no clearing.
module cdg_graphics_command_decoder import cdg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_func,
   input  logic [5:0]   req_instruction,
   input  logic [47:0]  req_data_lo,
   input  logic [47:0]  req_data_hi,
   input  logic [8:0]   req_read_x,
   input  logic [7:0]   req_read_y,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_status,
   output logic [3:0]   rsp_color_index,
   output logic [7:0]   rsp_red,
   output logic [7:0]   rsp_green,
   output logic [7:0]   rsp_blue
);
   cmd_type  cmd;
   stat_type stat;

   cdg_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .stat
   );

   cdg_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .req_func, .req_instruction, .req_data_lo, .req_data_hi,
      .req_read_x, .req_read_y,
      .rsp_status, .rsp_color_index, .rsp_red, .rsp_green, .rsp_blue
   );
endmodule

// ===== tb/cdg_graphics_command_decoder_test.sv =====
// self-checking testbench for the graphics command decoder
`timescale 1ns / 1ps
module cdg_graphics_command_decoder_test;
   import cdg_pkg::*;

   typedef struct {
      logic        func;
      logic [5:0]  instr;
      logic [47:0] lo;
      logic [47:0] hi;
      logic [8:0]  x;
      logic [7:0]  y;
      int          gap;
      bit          drain;
   } cmd_item_type;

   typedef struct {
      logic [1:0] status;
      logic [3:0] ci;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_func;
   logic [5:0]  req_instruction;
   logic [47:0] req_data_lo;
   logic [47:0] req_data_hi;
   logic [8:0]  req_read_x;
   logic [7:0]  req_read_y;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_color_index;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;

   cmd_item_type  pending_cmds[$];
   pixel_rsp_type expected_rsps[$];
   logic [3:0]  frame_model[FrameDepth];
   logic [11:0] palette_model[16];
   int          mismatches = 0;
   int          rsp_count = 0;
   int          rsp_hold = 0;

   cdg_graphics_command_decoder u_top (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [5:0] symbol(logic [47:0] lo, logic [47:0] hi, int k);
      logic [47:0] w;
      w = (k < 8) ? lo : hi;
      return w[(k % 8) * 6 +: 6];
   endfunction

   // updates the frame and palette model, returns the expected result
   function automatic pixel_rsp_type decode_command(cmd_item_type c);
      pixel_rsp_type r;
      logic [5:0]  s[16];
      logic [3:0]  c0, c1, col;
      logic [11:0] e;
      int          y0, x0, yy, xx, idx;
      r = '{StatusDone, 4'd0, 8'd0, 8'd0, 8'd0};
      for (int k = 0; k < 16; k++) s[k] = symbol(c.lo, c.hi, k);
      if (c.func) begin
         if (c.x < FrameWidth && c.y < FrameHeight) begin
            r.ci = frame_model[c.y * FrameWidth + c.x];
            e = palette_model[r.ci];
            r.red = 8'(e[11:8] * 15);
            r.green = 8'(e[7:4] * 15);
            r.blue = 8'(e[3:0] * 15);
         end
         return r;
      end
      case (c.instr) inside
         InstrPreset: begin
            if (s[1][3:0] == 4'd0)
               for (int i = 0; i < FrameDepth; i++) frame_model[i] = s[0][3:0];
         end
         InstrTile, InstrTileXor: begin
            c0 = s[0][3:0];
            c1 = s[1][3:0];
            y0 = s[2][4:0] * 12;
            x0 = s[3] * 6;
            for (int rr = 0; rr < 12; rr++) begin
               yy = y0 + rr;
               for (int p = 0; p < 6; p++) begin
                  xx = x0 + p;
                  if (yy < FrameHeight && xx < FrameWidth) begin
                     idx = yy * FrameWidth + xx;
                     col = s[4 + rr][5 - p] ? c1 : c0;
                     frame_model[idx] = (c.instr == InstrTileXor) ?
                        (frame_model[idx] ^ col) : col;
                  end
               end
            end
         end
         InstrPalLo, InstrPalHi: begin
            for (int i = 0; i < 8; i++)
               palette_model[(c.instr == InstrPalHi ? 8 : 0) + i] =
                  {s[2*i][5:2], s[2*i][1:0], s[2*i+1][5:4], s[2*i+1][3:0]};
         end
         InstrBorder, InstrScroll, InstrScrollCopy, InstrTransp: r.status = StatusUnimpl;
         default: r.status = StatusUnknown;
      endcase
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      cmd_item_type c;
      logic      fire;
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < 16; i++) palette_model[i] = 12'd0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            c.func = req_func; c.instr = req_instruction;
            c.lo = req_data_lo; c.hi = req_data_hi;
            c.x = req_read_x; c.y = req_read_y;
            expected_rsps.push_back(decode_command(c));
         end
         if (!req_valid || fire) begin
            if (pending_cmds.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_cmds[0].gap > 0) begin
               pending_cmds[0].gap--;
               req_valid <= 1'b0;
            end else if (pending_cmds[0].drain && (expected_rsps.size() != 0 || fire)) begin
               req_valid <= 1'b0;
            end else begin
               c = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_func <= c.func;
               req_instruction <= c.instr;
               req_data_lo <= c.lo;
               req_data_hi <= c.hi;
               req_read_x <= c.x;
               req_read_y <= c.y;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result item");
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status || rsp_color_index !== e.ci ||
                   rsp_red !== e.red || rsp_green !== e.green || rsp_blue !== e.blue) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp st %0d ci %0d rgb %0d %0d %0d, ",
                               "got st %0d ci %0d rgb %0d %0d %0d"},
                        e.status, e.ci, e.red, e.green, e.blue, rsp_status,
                        rsp_color_index, rsp_red, rsp_green, rsp_blue);
               end
            end
            rsp_count++;
            // one long hold-off so the block backs up and stalls its input
            if (rsp_count == 400) rsp_hold = 600;
            else if ((rsp_count / 100) % 3 == 1) rsp_hold = 0;
            else rsp_hold = $urandom_range(0, 5);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   function automatic cmd_item_type rand_cmd(int gap);
      cmd_item_type c;
      c.func = 1'b0;
      c.instr = 6'($urandom_range(0, 63));
      c.lo = 48'({$urandom, $urandom});
      c.hi = 48'({$urandom, $urandom});
      c.x = 9'($urandom_range(0, 511));
      c.y = 8'($urandom_range(0, 255));
      c.gap = gap;
      c.drain = 0;
      return c;
   endfunction

   task automatic add_cmd(logic func, logic [5:0] instr, logic [47:0] lo, logic [47:0] hi,
                          logic [8:0] x, logic [7:0] y);
      cmd_item_type c;
      c = rand_cmd($urandom_range(0, 5));
      c.func = func; c.instr = instr; c.lo = lo; c.hi = hi; c.x = x; c.y = y;
      pending_cmds.push_back(c);
   endtask

   initial begin
      cmd_item_type c;
      int        sel, gap, last_x, last_y;
      logic [47:0] ones;
      ones = '1;
      req_valid = 0; req_func = 0; req_instruction = 0; req_data_lo = 0;
      req_data_hi = 0; req_read_x = 0; req_read_y = 0; rsp_ready = 0;
      reset = 1;
      // frame must be fully written before any read or xor tile
      add_cmd(1'b0, InstrPreset, 48'h5, 48'h0, 0, 0);
      add_cmd(1'b1, 6'd0, 0, 0, 0, 0);
      add_cmd(1'b1, 6'd0, 0, 0, 299, 215);
      add_cmd(1'b0, InstrPalLo, ones, ones, 0, 0);
      add_cmd(1'b0, InstrPalHi, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 0, 0);
      add_cmd(1'b1, 6'd0, ones, ones, 10, 10);
      add_cmd(1'b0, InstrTile, 48'h0_0000_0000_0_9_3, ones, 0, 0);
      add_cmd(1'b1, 6'd0, 0, 0, 0, 0);
      add_cmd(1'b0, InstrTileXor, {30'h2aaaaaaa, 6'd0, 6'd0, 6'h0f}, ones, 0, 0);
      add_cmd(1'b1, 6'd0, 0, 0, 5, 11);
      add_cmd(1'b0, InstrTile, {24'($urandom), 6'd49, 6'd17, 6'h3c, 6'h3e},
              48'({$urandom, $urandom}), 0, 0);
      add_cmd(1'b0, InstrTile, {24'($urandom), 6'd63, 6'd31, 6'h3c, 6'h3e}, ones, 0, 0);
      add_cmd(1'b0, InstrTileXor, {24'($urandom), 6'd50, 6'd18, 6'h3c, 6'h3e}, ones, 0, 0);
      add_cmd(1'b1, 6'd0, 0, 0, 299, 215);
      add_cmd(1'b1, 6'd0, 0, 0, 300, 0);
      add_cmd(1'b1, 6'd0, 0, 0, 0, 216);
      add_cmd(1'b1, 6'h3f, ones, ones, 511, 255);
      add_cmd(1'b0, InstrPreset, 48'hfc7, 48'h0, 0, 0);
      add_cmd(1'b0, InstrBorder, ones, ones, 0, 0);
      add_cmd(1'b0, InstrScroll, 0, 0, 0, 0);
      add_cmd(1'b0, InstrScrollCopy, ones, 0, 0, 0);
      add_cmd(1'b0, InstrTransp, 0, ones, 0, 0);
      add_cmd(1'b0, 6'd0, 0, 0, 0, 0);
      add_cmd(1'b0, 6'd63, ones, ones, 0, 0);
      last_x = 0; last_y = 0;
      for (int i = 0; i < 1250; i++) begin
         gap = ((i / 100) % 3 == 0) ? 0 : $urandom_range(0, 5);
         c = rand_cmd(gap);
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            c.func = 1'b1;
            if (sel < 15) begin
               c.x = 9'(last_x + $urandom_range(0, 5));
               c.y = 8'(last_y + $urandom_range(0, 11));
            end else if (sel < 31) begin
               c.x = 9'($urandom_range(0, FrameWidth - 1));
               c.y = 8'($urandom_range(0, FrameHeight - 1));
            end
         end else if (sel < 75) begin
            c.instr = (sel < 60) ? InstrTile : InstrTileXor;
            c.lo[17:12] = {1'b0, 5'($urandom_range(0, 17))};
            c.lo[23:18] = 6'($urandom_range(0, 49));
            if (sel % 8 == 0) begin
               c.lo[17:12] = 6'($urandom_range(0, 63));
               c.lo[23:18] = 6'($urandom_range(0, 63));
            end
            last_y = (c.lo[16:12] * 12 < FrameHeight) ? c.lo[16:12] * 12 : 0;
            last_x = (c.lo[23:18] * 6 < FrameWidth) ? c.lo[23:18] * 6 : 0;
         end else if (sel < 87) begin
            c.instr = (sel < 81) ? InstrPalLo : InstrPalHi;
         end else if (sel < 89) begin
            c.instr = InstrPreset;
            if (sel == 88 && $urandom_range(0, 1))
               c.lo[11:6] = {2'($urandom_range(0, 3)), 4'd0};
         end
         if (i == 600) c.drain = 1;
         pending_cmds.push_back(c);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_cmds.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("cdg_graphics_command_decoder_test OK");
      else
         $display("cdg_graphics_command_decoder_test NOT OK");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("cdg_graphics_command_decoder_test NOT OK");
      $finish;
   end
endmodule
